// ----- rtl/core/srecord_encoder_macros.svh -----
// Assertion macros used by the S-record encoder checker
`ifndef SRECORD_ENCODER_MACROS_SVH
`define SRECORD_ENCODER_MACROS_SVH

// same-cycle implication
`define SREC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SREC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/srec_pkg.sv -----
// Types, constants and helpers of the S-record encoder
package srec_pkg;

  localparam int unsigned RecordBytesDef = 16;
  localparam int unsigned BufDepth       = 16;
  localparam int unsigned IdxW           = $clog2(BufDepth);
  localparam int unsigned FillW          = IdxW + 1;
  localparam int unsigned ResW           = 4;
  localparam int unsigned AddrW          = 32;

  localparam logic [7:0]       BlankByte = 8'hFF;
  localparam logic [AddrW-1:0] Addr16Lim = 32'h0001_0000;
  localparam logic [AddrW-1:0] Addr24Lim = 32'h0100_0000;

  localparam logic [6:0] CharS  = 7'h53;
  localparam logic [6:0] CharNl = 7'h0A;
  localparam logic [6:0] Char0  = 7'h30;
  localparam logic [6:0] CharA  = 7'h41;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_item_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = Char0 + {3'b000, nib};
    end else begin
      c = CharA + {3'b000, nib} - 7'd10;
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/srec_mod_unit.sv -----
// Table-driven remainder of a 32-bit address by the record length
module srec_mod_unit #(
  parameter int unsigned RECORD_BYTES = srec_pkg::RecordBytesDef
) (
  input  logic [srec_pkg::AddrW-1:0] value_i,
  output logic [srec_pkg::ResW-1:0]  res_o
);

  localparam int unsigned RW   = srec_pkg::ResW;
  localparam int unsigned NibN = srec_pkg::AddrW / 4;
  localparam int unsigned SumW = RW + $clog2(NibN);

  typedef logic [NibN-1:0][15:0][RW-1:0]   nib_tab_t;
  typedef logic [(1 << SumW)-1:0][RW-1:0]  fold_tab_t;

  // residue of each nibble value at each nibble position
  function automatic nib_tab_t nib_table();
    nib_tab_t    t;
    int unsigned w;
    t = '0;
    w = 1 % RECORD_BYTES;
    for (int unsigned p = 0; p < NibN; p++) begin
      for (int unsigned n = 0; n < 16; n++) begin
        t[p][n] = RW'((n * w) % RECORD_BYTES);
      end
      w = (w * 16) % RECORD_BYTES;
    end
    return t;
  endfunction

  // residue of a sum of nibble residues
  function automatic fold_tab_t fold_table();
    fold_tab_t t;
    t = '0;
    for (int unsigned s = 0; s < (1 << SumW); s++) begin
      t[s] = RW'(s % RECORD_BYTES);
    end
    return t;
  endfunction

  localparam nib_tab_t  NibTab  = nib_table();
  localparam fold_tab_t FoldTab = fold_table();

  logic [SumW-1:0] acc [NibN+1];

  assign acc[0] = '0;

  for (genvar p = 0; p < NibN; p++) begin : g_nib
    assign acc[p+1] = acc[p] + SumW'(NibTab[p][value_i[p*4 +: 4]]);
  end

  assign res_o = FoldTab[acc[NibN]];

endmodule

// ----- rtl/core/srecord_encoder.sv -----
// S-record encoder: collects memory bytes and emits S1/S2/S3 record text
// Usage:
//   Input channel carries one memory byte per transfer with a flag marking the
//   last byte of the region. Output channel carries one ASCII character per
//   transfer; last_char flags the newline that ends a record.
//   cfg_we_i/cfg_wdata_i write the region start address; the user must do so while the
//   block idles, unenforced; its record phase comes from a table-driven remainder.
// Timing:
//   A byte that does not close a record, or closes an all-0xFF record, leaves
//   input open for the next byte. A closing byte starts a run of 2*N + 2*A + 7
//   characters (N data bytes, A address bytes), one per cycle from the character
//   sequencer while the output is not stalled; the first passes through the
//   state register and then the output register, and input stays stalled for
//   the whole run.
// Reset clears the record state and the start address to zero.
// A stalled output holds its character; the sequencer waits on it, and input
// stays stalled until the newline has been handed to the output register.
module srecord_encoder #(
  parameter int unsigned RECORD_BYTES = srec_pkg::RecordBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [srec_pkg::AddrW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  srec_pkg::in_item_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output srec_pkg::out_item_t        out_data_o
);

  localparam int unsigned RW = srec_pkg::ResW;
  localparam int unsigned FW = srec_pkg::FillW;
  localparam int unsigned AW = srec_pkg::AddrW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SREC = 3'd1;
  localparam logic [2:0] ST_TYPE = 3'd2;
  localparam logic [2:0] ST_HEX  = 3'd3;
  localparam logic [2:0] ST_NL   = 3'd4;

  localparam logic [RW-1:0] ResLast = RW'(RECORD_BYTES - 1);
  localparam logic [FW-1:0] FillMax = FW'(RECORD_BYTES);

  logic [RW-1:0]   cfg_res;

  logic [AW-1:0]   start_q, start_d;
  logic [RW-1:0]   start_res_q, start_res_d;
  logic [AW-1:0]   next_addr_q, next_addr_d;
  logic [RW-1:0]   next_res_q, next_res_d;
  logic [FW-1:0]   fill_q, fill_d;
  logic            blank_q, blank_d;
  logic [AW-1:0]   rec_addr_q, rec_addr_d;
  logic [2:0]      state_q, state_d;
  logic [FW-1:0]   size_q, size_d;
  logic [2:0]      ab_q, ab_d;
  logic [AW-1:0]   addr_sh_q, addr_sh_d;
  logic [7:0]      sum_q, sum_d;
  logic [FW-1:0]   byte_idx_q, byte_idx_d;
  logic            nib_q, nib_d;
  logic [srec_pkg::IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            out_valid_q;
  srec_pkg::out_item_t out_q, out_d;
  logic [7:0]      buf_q [srec_pkg::BufDepth];

  logic            in_acc, adv, emit_go, close, blank_acc, is_addr, is_data;
  logic [AW-1:0]   rec_addr_acc;
  logic [FW-1:0]   fill_inc, total_last;
  logic [RW-1:0]   res_inc;
  logic [2:0]      ab_acc;
  logic [7:0]      count_acc, cur_byte;
  logic [3:0]      nibble;

  srec_mod_unit #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_mod (
    .value_i(cfg_wdata_i),
    .res_o  (cfg_res)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_q || !out_stall_i;
  assign emit_go    = (state_q != ST_IDLE) && adv;

  always_comb begin
    rec_addr_acc = (fill_q == '0) ? next_addr_q : rec_addr_q;
    blank_acc    = ((fill_q == '0) || blank_q) && (in_data_i.data_byte == srec_pkg::BlankByte);
    fill_inc     = fill_q + 1'b1;
    if (next_addr_q == '1) begin
      res_inc = '0;
    end else if (next_res_q == ResLast) begin
      res_inc = '0;
    end else begin
      res_inc = next_res_q + 1'b1;
    end
    close = in_data_i.last_byte || (res_inc == '0) || (fill_inc >= FillMax);
    priority if (rec_addr_acc < srec_pkg::Addr16Lim) begin
      ab_acc = 3'd2;
    end else if (rec_addr_acc < srec_pkg::Addr24Lim) begin
      ab_acc = 3'd3;
    end else begin
      ab_acc = 3'd4;
    end
    count_acc = 8'(fill_inc) + {5'b0, ab_acc} + 8'd1;
  end

  always_comb begin
    total_last = FW'(ab_q) + size_q + 1'b1;
    is_addr    = (byte_idx_q != '0) && (byte_idx_q <= FW'(ab_q));
    is_data    = (byte_idx_q > FW'(ab_q)) && (byte_idx_q < total_last);
    priority if (byte_idx_q == '0) begin
      cur_byte = sum_q;
    end else if (is_addr) begin
      cur_byte = addr_sh_q[AW-1 -: 8];
    end else if (is_data) begin
      cur_byte = buf_q[rd_idx_q];
    end else begin
      cur_byte = ~sum_q;
    end
    nibble = nib_q ? cur_byte[3:0] : cur_byte[7:4];
  end

  always_comb begin
    out_d.last_char = 1'b0;
    unique case (state_q)
      ST_SREC: out_d.char_code = srec_pkg::CharS;
      ST_TYPE: out_d.char_code = srec_pkg::Char0 + {4'b0, ab_q} - 7'd1;
      ST_HEX:  out_d.char_code = srec_pkg::hex_char(nibble);
      ST_NL: begin
        out_d.char_code = srec_pkg::CharNl;
        out_d.last_char = 1'b1;
      end
      default: out_d.char_code = srec_pkg::CharNl;
    endcase
  end

  always_comb begin
    start_d     = start_q;
    start_res_d = start_res_q;
    next_addr_d = next_addr_q;
    next_res_d  = next_res_q;
    fill_d      = fill_q;
    blank_d     = blank_q;
    rec_addr_d  = rec_addr_q;
    state_d     = state_q;
    size_d      = size_q;
    ab_d        = ab_q;
    addr_sh_d   = addr_sh_q;
    sum_d       = sum_q;
    byte_idx_d  = byte_idx_q;
    nib_d       = nib_q;
    rd_idx_d    = rd_idx_q;

    if (cfg_we_i) begin
      start_d     = cfg_wdata_i;
      start_res_d = cfg_res;
      if (fill_q == '0) begin
        next_addr_d = cfg_wdata_i;
        next_res_d  = cfg_res;
      end
    end

    if (in_acc) begin
      rec_addr_d = rec_addr_acc;
      fill_d     = fill_inc;
      blank_d    = blank_acc;
      if (in_data_i.last_byte) begin
        next_addr_d = start_q;
        next_res_d  = start_res_q;
      end else begin
        next_addr_d = next_addr_q + 1'b1;
        next_res_d  = res_inc;
      end
      if (close) begin
        fill_d  = '0;
        blank_d = 1'b1;
        if (!blank_acc) begin
          state_d    = ST_SREC;
          size_d     = fill_inc;
          ab_d       = ab_acc;
          sum_d      = count_acc;
          byte_idx_d = '0;
          nib_d      = 1'b0;
          rd_idx_d   = '0;
          unique case (ab_acc)
            3'd2:    addr_sh_d = {rec_addr_acc[15:0], 16'h0000};
            3'd3:    addr_sh_d = {rec_addr_acc[23:0], 8'h00};
            default: addr_sh_d = rec_addr_acc;
          endcase
        end
      end
    end

    if (emit_go) begin
      unique case (state_q)
        ST_SREC: state_d = ST_TYPE;
        ST_TYPE: state_d = ST_HEX;
        ST_HEX: begin
          if (!nib_q) begin
            nib_d = 1'b1;
          end else begin
            nib_d      = 1'b0;
            byte_idx_d = byte_idx_q + 1'b1;
            if (is_addr) begin
              addr_sh_d = {addr_sh_q[AW-9:0], 8'h00};
            end
            if (is_data) begin
              rd_idx_d = rd_idx_q + 1'b1;
            end
            if (is_addr || is_data) begin
              sum_d = sum_q + cur_byte;
            end
            if (byte_idx_q == total_last) begin
              state_d = ST_NL;
            end
          end
        end
        ST_NL:   state_d = ST_IDLE;
        default: state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      start_res_q <= '0;
      next_addr_q <= '0;
      next_res_q  <= '0;
      fill_q      <= '0;
      blank_q     <= 1'b1;
      rec_addr_q  <= '0;
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      start_q     <= start_d;
      start_res_q <= start_res_d;
      next_addr_q <= next_addr_d;
      next_res_q  <= next_res_d;
      fill_q      <= fill_d;
      blank_q     <= blank_d;
      rec_addr_q  <= rec_addr_d;
      state_q     <= state_d;
      if (emit_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    ab_q       <= ab_d;
    addr_sh_q  <= addr_sh_d;
    sum_q      <= sum_d;
    byte_idx_q <= byte_idx_d;
    nib_q      <= nib_d;
    rd_idx_q   <= rd_idx_d;
    if (emit_go) begin
      out_q <= out_d;
    end
    if (in_acc) begin
      buf_q[fill_q[srec_pkg::IdxW-1:0]] <= in_data_i.data_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/srec_checker.sv -----
// Port-level checker for the S-record encoder, bound to the top level
`include "srecord_encoder_macros.svh"

module srec_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic [srec_pkg::AddrW-1:0] cfg_wdata_i,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input srec_pkg::in_item_t         in_data_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input srec_pkg::out_item_t        out_data_o
);

  logic run_open;
  logic nl_shown;
  logic unused_ok;

  assign run_open  = out_valid_o && !out_data_o.last_char;
  assign nl_shown  = out_valid_o && (out_data_o.char_code == srec_pkg::CharNl);
  assign unused_ok = cfg_we_i | (|cfg_wdata_i) | in_valid_i | (|in_data_i);

  `SREC_ASSERT_NOW(a_last_is_nl, out_valid_o && out_data_o.last_char, nl_shown, "last_char off newline")
  `SREC_ASSERT_NOW(a_nl_is_last, nl_shown, out_data_o.last_char, "newline without last_char")
  `SREC_ASSERT_NEXT(a_run_gapless, run_open && !out_stall_i, out_valid_o, "gap inside a record")
  `SREC_ASSERT_NOW(a_stall_in_run, run_open, in_stall_o, "input open during a record")

endmodule

bind srecord_encoder srec_checker u_srec_checker (.*);

// ----- bench/srecord_encoder_tb.sv -----
// Self-checking bench for the S-record encoder: directed table, random regions, S-record predictor
module srecord_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RecBytes  = srec_pkg::RecordBytesDef;
  localparam int          RandItems = 165;
  localparam int unsigned SettleCyc = 12;
  localparam int unsigned HoldCyc   = 400;
  localparam int unsigned IdleLimit = 4000;

  typedef struct packed {
    bit                         is_cfg;
    logic [srec_pkg::AddrW-1:0] addr;
    srec_pkg::in_item_t         item;
    bit                         lit;
  } dir_row_t;

  logic                       clk_i;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic [srec_pkg::AddrW-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i  = 1'b0;
  srec_pkg::in_item_t         in_data_i   = '0;
  logic                       out_stall_i = 1'b1;
  logic                       in_stall_o;
  logic                       out_valid_o;
  srec_pkg::out_item_t        out_data_o;

  // predictor state
  logic [srec_pkg::AddrW-1:0] start_addr;
  logic [srec_pkg::AddrW-1:0] run_addr;
  logic [srec_pkg::AddrW-1:0] rec_addr;
  logic [srec_pkg::FillW-1:0] rec_fill;
  logic                       rec_blank;
  logic [7:0]                 rec_buf [srec_pkg::BufDepth];

  string               hex_set = "0123456789ABCDEF";
  srec_pkg::out_item_t record_text [$];
  srec_pkg::out_item_t expected_chars [$];
  dir_row_t            dir_rows [$];
  string               dir_text [$];

  int errors      = 0;
  int idle_cycles = 0;
  int send_calm   = 0;
  int recv_calm   = 0;
  bit hold_req    = 1'b0;

  srecord_encoder #(
    .RECORD_BYTES(RecBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(15, 50);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic void push_char(logic [6:0] c, bit lst);
    srec_pkg::out_item_t o;
    o.char_code = c;
    o.last_char = lst;
    record_text.push_back(o);
  endfunction

  function automatic void push_hex(logic [7:0] b);
    push_char(7'(hex_set[b[7:4]]), 1'b0);
    push_char(7'(hex_set[b[3:0]]), 1'b0);
  endfunction

  function automatic void encode_byte(srec_pkg::in_item_t it);
    logic       closing;
    logic [7:0] sum;
    logic [7:0] cnt;
    int         nab;
    record_text.delete();
    if (rec_fill == 0) begin
      rec_addr  = run_addr;
      rec_blank = 1'b1;
    end
    if (rec_fill < srec_pkg::BufDepth) rec_buf[rec_fill[srec_pkg::IdxW-1:0]] = it.data_byte;
    rec_fill = rec_fill + 1'b1;
    if (it.data_byte != srec_pkg::BlankByte) rec_blank = 1'b0;
    run_addr = run_addr + 1'b1;
    closing = it.last_byte || (run_addr % RecBytes) == 0 ||
              rec_fill >= RecBytes || rec_fill >= srec_pkg::BufDepth;
    if (it.last_byte) run_addr = start_addr;
    if (!closing) return;
    if (!rec_blank) begin
      if (rec_addr < srec_pkg::Addr16Lim) nab = 2;
      else if (rec_addr < srec_pkg::Addr24Lim) nab = 3;
      else nab = 4;
      cnt = 8'(rec_fill) + 8'(nab) + 8'd1;
      push_char(srec_pkg::CharS, 1'b0);
      push_char(srec_pkg::Char0 + 7'(nab - 1), 1'b0);
      push_hex(cnt);
      sum = cnt;
      for (int i = nab - 1; i >= 0; i--) begin
        push_hex(rec_addr[i*8 +: 8]);
        sum = sum + rec_addr[i*8 +: 8];
      end
      for (int i = 0; i < int'(rec_fill) && i < srec_pkg::BufDepth; i++) begin
        push_hex(rec_buf[i]);
        sum = sum + rec_buf[i];
      end
      push_hex(~sum);
      push_char(srec_pkg::CharNl, 1'b1);
    end
    rec_fill  = '0;
    rec_blank = 1'b1;
  endfunction

  function automatic void queue_prediction(srec_pkg::in_item_t it);
    encode_byte(it);
    foreach (record_text[i]) expected_chars.push_back(record_text[i]);
  endfunction

  function automatic void add_row(bit is_cfg, logic [srec_pkg::AddrW-1:0] addr,
                                  logic [7:0] d, bit l, bit lit, string text);
    dir_row_t r;
    r.is_cfg         = is_cfg;
    r.addr           = addr;
    r.item.data_byte = d;
    r.item.last_byte = l;
    r.lit            = lit;
    dir_rows.push_back(r);
    dir_text.push_back(text);
  endfunction

  task automatic send_byte(srec_pkg::in_item_t it);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_start(logic [srec_pkg::AddrW-1:0] a);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    start_addr = a;
    if (rec_fill == 0) run_addr = a;
  endtask

  initial begin : stimulus
    srec_pkg::in_item_t         it;
    srec_pkg::out_item_t        ch;
    logic [srec_pkg::AddrW-1:0] base;
    string                      text;
    int                         sent;
    int                         region;
    int                         len;
    bit                         blank_run;
    bit                         open_end;

    start_addr = '0;
    run_addr   = '0;
    rec_addr   = '0;
    rec_fill   = '0;
    rec_blank  = 1'b1;

    add_row(1'b0, '0, 8'h00, 1'b1, 1'b1, "S104000000FB\n");
    add_row(1'b0, '0, 8'hFF, 1'b1, 1'b1, "");
    add_row(1'b1, 32'h0000_FFFE, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'h12, 1'b0, 1'b1, "");
    add_row(1'b0, '0, 8'h34, 1'b0, 1'b1, "S105FFFE1234B7\n");
    add_row(1'b1, 32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'hAB, 1'b0, 1'b1, "S306FFFFFFFFAB52\n");
    add_row(1'b0, '0, 8'h00, 1'b0, 1'b1, "");
    add_row(1'b0, '0, 8'hFF, 1'b1, 1'b1, "S105000000FFFB\n");
    add_row(1'b0, '0, 8'h7F, 1'b1, 1'b0, "");
    add_row(1'b1, 32'h00FF_FFFF, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'h5A, 1'b1, 1'b0, "");
    add_row(1'b1, 32'h0100_0000, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'hFF, 1'b0, 1'b1, "");
    add_row(1'b0, '0, 8'hFF, 1'b0, 1'b1, "");
    add_row(1'b0, '0, 8'hFF, 1'b1, 1'b1, "");
    add_row(1'b1, 32'h0000_2000, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'h11, 1'b0, 1'b1, "");
    add_row(1'b1, 32'h0034_5678, 8'h00, 1'b0, 1'b0, "");
    add_row(1'b0, '0, 8'h22, 1'b1, 1'b1, "S10520001122A7\n");
    add_row(1'b0, '0, 8'h80, 1'b1, 1'b0, "");

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        write_start(dir_rows[r].addr);
      end else begin
        send_byte(dir_rows[r].item);
        if (dir_rows[r].lit) begin
          encode_byte(dir_rows[r].item);
          text = dir_text[r];
          for (int i = 0; i < text.len(); i++) begin
            ch.char_code = 7'(text[i]);
            ch.last_char = (i == text.len() - 1);
            expected_chars.push_back(ch);
          end
        end else begin
          queue_prediction(dir_rows[r].item);
        end
      end
    end

    sent   = 0;
    region = 0;
    while (sent < RandItems) begin
      if (region == 0 || $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 6))
          0:       base = 32'($urandom_range(0, 16'hFFFF));
          1:       base = 32'h0000_FFF0 + 32'($urandom_range(0, 15));
          2:       base = {8'h00, 24'($urandom)};
          3:       base = 32'h00FF_FFF0 + 32'($urandom_range(0, 31));
          4:       base = $urandom;
          5:       base = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
          default: base = '0;
        endcase
        write_start(base);
      end
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 40) : $urandom_range(1, 18);
      if (region == 3) begin
        hold_req = 1'b1;
        len      = 40;
      end
      if (len > RandItems - sent) begin
        len = RandItems - sent;
      end
      blank_run = ($urandom_range(0, 4) == 0);
      open_end  = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len; k++) begin
        it.data_byte = (blank_run && $urandom_range(0, 7) != 0) ?
                       srec_pkg::BlankByte : 8'($urandom);
        it.last_byte = (k == len - 1 && !open_end) || ($urandom_range(0, 39) == 0);
        send_byte(it);
        queue_prediction(it);
        sent++;
      end
      region++;
    end

    wait_drained();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : drain_chars
    int                  gap;
    srec_pkg::out_item_t want;
    wait (rst_ni);
    forever begin
      gap = draw_wait(recv_calm);
      if (hold_req) begin
        hold_req = 1'b0;
        gap      = HoldCyc;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      if (expected_chars.size() == 0) begin
        $error("char_code: expected none, got %h", out_data_o.char_code);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data_o.char_code !== want.char_code) begin
          $error("char_code: expected %h, got %h", want.char_code, out_data_o.char_code);
          errors++;
        end
        if (out_data_o.last_char !== want.last_char) begin
          $error("last_char: expected %b, got %b", want.last_char, out_data_o.last_char);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/srec_pkg.sv
rtl/core/srec_mod_unit.sv
rtl/core/srecord_encoder.sv
rtl/core/srec_checker.sv
bench/srecord_encoder_tb.sv
